@@ src/pmt_pkg.sv @@
// shared types and constants for the multichannel period meter
package pmt_pkg;

   // design constants
   localparam int NUM_CHANNELS = 4;
   localparam int STAMP_BITS   = 16;
   localparam int COUNT_BITS   = 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [STAMP_BITS-1:0] STAMP_ALL_ONES      = {STAMP_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] SILENCE_LIMIT_RESET = COUNT_BITS'(100);

   // item kinds
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // register index of silence_limit, taken from paddr[2]
   localparam logic REG_SILENCE_LIMIT = 1'b0;

   // input word
   typedef struct packed {
      logic        kind;
      logic [1:0]  channel;
      logic [15:0] timestamp;
   } req_type;

   // result word
   typedef struct packed {
      logic [15:0] period;
      logic        signal_lost;
   } rsp_type;

endpackage

@@ src/pmt_csr.sv @@
// configuration register block: silence limit behind an apb-style port
module pmt_csr
   import pmt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [COUNT_BITS-1:0]    silence_limit
);

   logic [COUNT_BITS-1:0] limit_ff;
   logic [COUNT_BITS-1:0] limit_in;
   logic                  wr_en;

   // write strobe in the access phase
   assign wr_en = psel && penable && pwrite && pready && (paddr[2] == REG_SILENCE_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (wr_en) begin
         limit_in = pwdata[COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= SILENCE_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_SILENCE_LIMIT) begin
         prdata = CSR_DATA_BITS'(limit_ff);
      end
   end

   assign pready        = 1'b1;
   assign silence_limit = limit_ff;

endmodule

@@ src/pmt_core.sv @@
// per-channel state: stamps, periods, silence counters and result selection
module pmt_core
   import pmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  req_type               item,
   input  logic [COUNT_BITS-1:0] silence_limit,
   output rsp_type               result
);

   logic [STAMP_BITS-1:0] last_stamp_ff [NUM_CHANNELS];
   logic [STAMP_BITS-1:0] last_stamp_in [NUM_CHANNELS];
   logic [STAMP_BITS-1:0] period_ff     [NUM_CHANNELS];
   logic [STAMP_BITS-1:0] period_in     [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] silence_ff    [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] silence_in    [NUM_CHANNELS];
   logic [STAMP_BITS-1:0] stamp;

   assign stamp = STAMP_BITS'(item.timestamp);

   // next state for every lane
   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         last_stamp_in[i] = last_stamp_ff[i];
         period_in[i]     = period_ff[i];
         silence_in[i]    = silence_ff[i];
         if (step) begin
            if (item.kind == KIND_EDGE) begin
               if (32'(item.channel) == i) begin
                  period_in[i]     = stamp - last_stamp_ff[i];
                  last_stamp_in[i] = stamp;
                  silence_in[i]    = '0;
               end
            end else begin
               if (silence_ff[i] < silence_limit) begin
                  silence_in[i] = silence_ff[i] + COUNT_BITS'(1);
               end else begin
                  period_in[i] = STAMP_ALL_ONES;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_stamp_ff[i] <= '0;
            period_ff[i]     <= '0;
            silence_ff[i]    <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_stamp_ff[i] <= last_stamp_in[i];
            period_ff[i]     <= period_in[i];
            silence_ff[i]    <= silence_in[i];
         end
      end
   end

   // report the named channel after the update, zero when out of range
   always_comb begin
      result = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (32'(item.channel) == i) begin
            result.period      = 16'(period_in[i]);
            result.signal_lost = (silence_in[i] >= silence_limit);
         end
      end
   end

endmodule

@@ src/multichannel_period_meter_timeout.sv @@
// an accepted word sits in the input register, then moves to the result register that drives rsp
// one word per cycle unless rsp stalls; channel state updates as a word leaves the input register
// the input register refills in the cycle a result is taken, so a full pipe keeps streaming
// reset (synchronous, active high) empties both registers, clears stamps, periods and
// silence counters, and sets the silence limit to 100
module multichannel_period_meter_timeout
   import pmt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   req_type               in_item_ff;
   req_type               in_item_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rsp_type               out_data_ff;
   rsp_type               out_data_in;
   logic                  advance;
   logic [COUNT_BITS-1:0] silence_limit;
   rsp_type               result;

   pmt_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .silence_limit (silence_limit)
   );

   pmt_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .item          (in_item_ff),
      .silence_limit (silence_limit),
      .result        (result)
   );

   // word moves from input to result register when the result slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ src/pmt_checker.sv @@
// port-level checks for the period meter, bound to the top level
module pmt_checker
   import pmt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   // input backpressure only comes from a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a stalled result");

   // an accepted word reaches the result port once the port drains
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted word did not reach the result port");

   // no result right after a reset edge
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multichannel_period_meter_timeout pmt_checker u_pmt_checker (.*);
